FILE: rtl/sst_pkg.sv
package sst_pkg;

    localparam int LEAVES    = 1024;
    localparam int LVL_W     = $clog2(LEAVES);
    localparam int NODE_W    = LVL_W + 1;
    localparam int IDX_W     = 11;
    localparam int DATA_W    = 32;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SUM   = 2'd1;
    localparam logic [1:0] OP_RIGHT = 2'd2;
    localparam logic [1:0] OP_LEFT  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOTFND = 2'd1;
    localparam logic [1:0] ST_BADARG = 2'd2;

    typedef struct packed {
        logic                 rd_en;
        logic [NODE_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [NODE_W-1:0]    wr_addr;
        logic [DATA_W-1:0]    wr_data;
    } mem_req_t;

endpackage

FILE: rtl/sst_node_ram.sv
module sst_node_ram
    import sst_pkg::*;
(
    input  logic               clk,
    input  mem_req_t           req,
    output logic [DATA_W-1:0]  rd_data
);

    logic [DATA_W-1:0] mem [0:2*LEAVES-1];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

FILE: rtl/sum_segment_tree.sv
// Segment tree of 32-bit wrapping sums over 1024 leaves, held in one node
// memory of 2048 words (node 1 is the root, leaf p is node p-1+1024). After
// reset the block sweeps the memory to zero, one word per cycle, so it takes
// no transaction until the sweep is done; configuration writes are taken
// throughout. Every transaction is handled alone by a sequencer around a
// memory with a registered read port: an add reads the leaf, writes it back
// updated and then, level by level, reads the sibling and writes the parent;
// a range sum reads the nodes that cover the range, climbing one level at a
// time; and the two searches run a range sum, then climb and descend the
// tree. A result is held in an output register; the next transaction is
// taken once that register has been emptied.
module sum_segment_tree
    import sst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                opcode,
    input  logic [IDX_W-1:0]          first_index,
    input  logic [IDX_W-1:0]          last_index,
    input  logic signed [DATA_W-1:0]  operand_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DATA_W-1:0]  sum_value,
    output logic [IDX_W-1:0]          position,
    output logic [1:0]                status
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ARD    = 4'd2;  // add: leaf read pending
    localparam logic [3:0] S_AUP    = 4'd3;  // add: sibling read pending
    localparam logic [3:0] S_RS     = 4'd4;  // range sum: choose next node
    localparam logic [3:0] S_RSW    = 4'd5;  // range sum: read pending
    localparam logic [3:0] S_RSD    = 4'd6;  // range sum finished
    localparam logic [3:0] S_UPR    = 4'd7;  // search climb: read pending
    localparam logic [3:0] S_DNI    = 4'd8;  // search descent: issue read
    localparam logic [3:0] S_DNR    = 4'd9;  // search descent: read pending
    localparam logic [3:0] S_DONE   = 4'd10;
    localparam logic [3:0] S_ADDW   = 4'd11; // add: write parent

    localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(LEAVES);

    logic [3:0]          state_reg, state_next;
    logic [IDX_W-1:0]    n_cfg_reg;
    logic [NODE_W-1:0]   clr_reg, clr_next;
    logic [1:0]          op_reg, op_next;
    // The left end has a spare bit so that stepping past the last leaf
    // does not wrap round to node zero.
    logic [NODE_W:0]     l_reg, l_next;
    logic [NODE_W-1:0]   r_reg, r_next;
    logic                side_reg, side_next;  // which end a range read serves
    logic [DATA_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic [DATA_W-1:0]   k_reg, k_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic                ov_reg, ov_next;
    logic [DATA_W-1:0]   os_reg, os_next;
    logic [IDX_W-1:0]    op_pos_reg, op_pos_next;
    logic [1:0]          ost_reg, ost_next;

    mem_req_t            req;
    logic [DATA_W-1:0]   rd_data;

    sst_node_ram u_ram
    (
        .clk         (clk),
        .req         (req),
        .rd_data     (rd_data)
    );

    // Effective number of leaves in use.
    logic [IDX_W-1:0] n_eff;
    assign n_eff = (n_cfg_reg > IDX_W'(LEAVES)) ? IDX_W'(LEAVES) : n_cfg_reg;

    function automatic logic [NODE_W-1:0] leaf_of(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] q;
        q = p - 1'b1;
        return NODE_W'(q[LVL_W-1:0]) | LEAF_BASE;
    endfunction

    function automatic logic [NODE_W-1:0] strip_zeros(input logic [NODE_W-1:0] x);
        logic [NODE_W-1:0] y;
        logic              done;
        y    = x;
        done = 1'b0;
        for (int i = 0; i < NODE_W; i++)
        begin
            if (!done && y != '0 && !y[0])
                y = y >> 1;
            else
                done = 1'b1;
        end
        return y;
    endfunction

    function automatic logic [NODE_W-1:0] strip_ones(input logic [NODE_W-1:0] x);
        logic [NODE_W-1:0] y;
        logic              done;
        y    = x;
        done = 1'b0;
        for (int i = 0; i < NODE_W; i++)
        begin
            if (!done && y[0])
                y = y >> 1;
            else
                done = 1'b1;
        end
        return (y == '0) ? NODE_W'(1) : y;
    endfunction

    logic [DATA_W-1:0] acc_try;
    logic              is_below;
    assign acc_try  = (op_reg == OP_LEFT) ? rd_data + a_reg : a_reg + rd_data;
    assign is_below = $signed(acc_try) < $signed(k_reg);

    logic [DATA_W-1:0] tot;
    assign tot = a_reg + b_reg;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        side_next   = side_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        node_next   = node_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        ov_next     = ov_reg;
        os_next     = os_reg;
        op_pos_next = op_pos_reg;
        ost_next    = ost_reg;
        req         = '0;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = clr_reg;
                req.wr_data = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == NODE_W'(2*LEAVES-1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    op_next     = opcode;
                    k_next      = operand_value;
                    val_next    = operand_value;
                    idx_next    = first_index;
                    a_next      = '0;
                    b_next      = '0;
                    os_next     = '0;
                    op_pos_next = '0;
                    ost_next    = ST_OK;
                    case (opcode)
                        OP_ADD:
                        begin
                            if (first_index >= 1 && first_index <= n_eff)
                            begin
                                node_next   = leaf_of(first_index);
                                req.rd_en   = 1'b1;
                                req.rd_addr = leaf_of(first_index);
                                state_next  = S_ARD;
                            end
                            else
                            begin
                                ost_next   = ST_BADARG;
                                state_next = S_DONE;
                            end
                        end
                        OP_SUM:
                        begin
                            if (first_index >= 1 && first_index <= last_index
                                && last_index <= n_eff)
                            begin
                                l_next     = {1'b0, leaf_of(first_index)};
                                r_next     = leaf_of(last_index);
                                state_next = S_RS;
                            end
                            else
                            begin
                                ost_next   = ST_BADARG;
                                state_next = S_DONE;
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (first_index >= 1 && first_index <= n_eff
                                && $signed(operand_value) >= 1)
                            begin
                                l_next     = {1'b0, leaf_of(first_index)};
                                r_next     = leaf_of(n_eff);
                                state_next = S_RS;
                            end
                            else
                            begin
                                ost_next   = ST_BADARG;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            idx_next = last_index;
                            if (last_index >= 1 && last_index <= n_eff
                                && $signed(operand_value) >= 1)
                            begin
                                l_next     = {1'b0, LEAF_BASE};
                                r_next     = leaf_of(last_index);
                                state_next = S_RS;
                            end
                            else
                            begin
                                ost_next   = ST_BADARG;
                                state_next = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_ARD:
            begin
                // Leaf value has arrived: write the updated leaf.
                val_next    = rd_data + val_reg;
                req.wr_en   = 1'b1;
                req.wr_addr = node_reg;
                req.wr_data = rd_data + val_reg;
                if (node_reg == NODE_W'(1))
                    state_next = S_DONE;
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = node_reg ^ NODE_W'(1);
                    state_next  = S_AUP;
                end
            end
            S_AUP:
            begin
                // Sibling value arrived; val_reg holds the current node.
                val_next   = val_reg + rd_data;
                node_next  = node_reg >> 1;
                state_next = S_ADDW;
            end
            S_ADDW:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = node_reg;
                req.wr_data = val_reg;
                if (node_reg == NODE_W'(1))
                    state_next = S_DONE;
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = node_reg ^ NODE_W'(1);
                    state_next  = S_AUP;
                end
            end
            S_RS:
            begin
                if (l_reg > {1'b0, r_reg})
                    state_next = S_RSD;
                else if (l_reg[0])
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = l_reg[NODE_W-1:0];
                    side_next   = 1'b0;
                    l_next      = l_reg + 1'b1;
                    state_next  = S_RSW;
                end
                else if (!r_reg[0])
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = r_reg;
                    side_next   = 1'b1;
                    r_next      = r_reg - 1'b1;
                    state_next  = S_RSW;
                end
                else
                begin
                    l_next = l_reg >> 1;
                    r_next = r_reg >> 1;
                end
            end
            S_RSW:
            begin
                if (side_reg)
                begin
                    b_next = b_reg + rd_data;
                    if (l_reg[0])
                        state_next = S_RS;
                    else
                    begin
                        l_next     = l_reg >> 1;
                        r_next     = r_reg >> 1;
                        state_next = S_RS;
                    end
                end
                else
                begin
                    a_next = a_reg + rd_data;
                    if (!r_reg[0])
                        state_next = S_RS;
                    else
                    begin
                        l_next     = l_reg >> 1;
                        r_next     = r_reg >> 1;
                        state_next = S_RS;
                    end
                end
            end
            S_RSD:
            begin
                if (op_reg == OP_SUM)
                begin
                    os_next    = tot;
                    state_next = S_DONE;
                end
                else if ($signed(tot) < $signed(k_reg))
                begin
                    ost_next   = ST_NOTFND;
                    state_next = S_DONE;
                end
                else
                begin
                    a_next = '0;
                    if (op_reg == OP_RIGHT)
                        node_next = strip_zeros(leaf_of(idx_reg));
                    else
                        node_next = strip_ones(leaf_of(idx_reg));
                    req.rd_en   = 1'b1;
                    req.rd_addr = (op_reg == OP_RIGHT) ? strip_zeros(leaf_of(idx_reg))
                                                       : strip_ones(leaf_of(idx_reg));
                    state_next  = S_UPR;
                end
            end
            S_UPR:
            begin
                if (!is_below)
                    state_next = S_DNI;
                else if (op_reg == OP_RIGHT)
                begin
                    a_next = acc_try;
                    if (((node_reg + 1'b1) & node_reg) == '0)
                    begin
                        op_pos_next = IDX_W'(n_eff + 1'b1);
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        node_next   = strip_zeros(node_reg + 1'b1);
                        req.rd_en   = 1'b1;
                        req.rd_addr = strip_zeros(node_reg + 1'b1);
                    end
                end
                else
                begin
                    a_next = acc_try;
                    if ((node_reg & (node_reg - 1'b1)) == '0)
                    begin
                        op_pos_next = IDX_W'(1);
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        node_next   = strip_ones(node_reg - 1'b1);
                        req.rd_en   = 1'b1;
                        req.rd_addr = strip_ones(node_reg - 1'b1);
                    end
                end
            end
            S_DNI:
            begin
                if (node_reg >= LEAF_BASE)
                begin
                    if (op_reg == OP_RIGHT)
                    begin
                        if (IDX_W'(node_reg ^ LEAF_BASE) >= n_eff)
                            op_pos_next = IDX_W'(n_eff + 1'b1);
                        else
                            op_pos_next = IDX_W'(node_reg ^ LEAF_BASE) + 1'b1;
                    end
                    else
                    begin
                        // position is l-1 = node+1-LEAVES, at least 1
                        if (node_reg == LEAF_BASE)
                            op_pos_next = IDX_W'(1);
                        else
                            op_pos_next = IDX_W'(node_reg - LEAF_BASE + 1'b1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    node_next   = (op_reg == OP_RIGHT) ? (node_reg << 1)
                                                       : ((node_reg << 1) | NODE_W'(1));
                    req.rd_en   = 1'b1;
                    req.rd_addr = (op_reg == OP_RIGHT) ? (node_reg << 1)
                                                       : ((node_reg << 1) | NODE_W'(1));
                    state_next  = S_DNR;
                end
            end
            S_DNR:
            begin
                if (is_below)
                begin
                    a_next    = acc_try;
                    node_next = (op_reg == OP_RIGHT) ? node_reg + 1'b1 : node_reg - 1'b1;
                end
                state_next = S_DNI;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            n_cfg_reg <= IDX_W'(LEAVES);
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            if (cfg_we)
                n_cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        side_reg   <= side_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        node_reg   <= node_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        os_reg     <= os_next;
        op_pos_reg <= op_pos_next;
        ost_reg    <= ost_next;
    end

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign sum_value = os_reg;
    assign position  = (ost_reg == ST_OK) ? op_pos_reg : '0;
    assign status    = ost_reg;

endmodule

FILE: dv/sum_segment_tree_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the sum segment tree, keeps its own copy of the
// node memory and predicts each result. Results are compared field by field.
module sum_segment_tree_checker
    import sst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_wdata,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [1:0]                opcode,
    input  logic [IDX_W-1:0]          first_index,
    input  logic [IDX_W-1:0]          last_index,
    input  logic signed [DATA_W-1:0]  operand_value,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [DATA_W-1:0]  sum_value,
    input  logic [IDX_W-1:0]          position,
    input  logic [1:0]                status,
    output int                        fail_count,
    output int                        pending
);

    typedef struct {
        logic [DATA_W-1:0] total;
        logic [IDX_W-1:0]  pos;
        logic [1:0]        stat;
    } tree_answer_t;

    logic [31:0]  node_q [0:2*LEAVES-1];
    logic [31:0]  leaves_used;
    tree_answer_t answer_q [$];

    assign pending = answer_q.size();

    function automatic int unsigned trailing_zeros(logic [31:0] x);
        int unsigned c;
        c = 0;
        if (x == 0)
            return 32;
        while (x[0] == 1'b0)
        begin
            x = x >> 1;
            c++;
        end
        return c;
    endfunction

    function automatic logic short_of(logic [31:0] s, int k);
        return $signed(s) < k;
    endfunction

    function automatic logic [31:0] span_total(logic [31:0] lo, logic [31:0] hi);
        logic [31:0] a, b, l, r;
        a = 0;
        b = 0;
        l = (lo - 1) | LEAVES;
        r = (hi - 1) | LEAVES;
        while (l <= r)
        begin
            if (l[0])
            begin
                a = a + node_q[l];
                l++;
            end
            if (!r[0])
            begin
                b = b + node_q[r];
                r--;
            end
            l = l >> 1;
            r = r >> 1;
        end
        return a + b;
    endfunction

    // Largest end with the running sum from start still short of k.
    function automatic logic [31:0] walk_right(logic [31:0] start, logic [31:0] n, int k);
        logic [31:0] node, acc;
        acc  = 0;
        node = (start - 1) | LEAVES;
        node = node >> trailing_zeros(node);
        while (short_of(acc + node_q[node], k))
        begin
            acc = acc + node_q[node];
            node++;
            if ((node & (node - 1)) == 0)
                return n;
            node = node >> trailing_zeros(node);
        end
        while (node < LEAVES)
        begin
            node = node << 1;
            if (short_of(acc + node_q[node], k))
            begin
                acc = acc + node_q[node];
                node++;
            end
        end
        return node ^ LEAVES;
    endfunction

    // Smallest start with the sum up to the end still short of k.
    function automatic logic [31:0] walk_left(logic [31:0] stop, int k);
        logic [31:0] node, acc;
        acc  = 0;
        node = (stop - 1) | LEAVES;
        node = node >> trailing_zeros(~node);
        if (node == 0)
            node = 1;
        while (short_of(node_q[node] + acc, k))
        begin
            acc = acc + node_q[node];
            node--;
            if (((node + 1) & node) == 0)
                return 1;
            node = node >> trailing_zeros(~node);
            if (node == 0)
                node = 1;
        end
        while (node < LEAVES)
        begin
            node = (node << 1) | 1;
            if (short_of(node_q[node] + acc, k))
            begin
                acc = acc + node_q[node];
                node--;
            end
        end
        return node + 2 - LEAVES;
    endfunction

    function automatic tree_answer_t apply_request(logic [1:0] op, logic [31:0] fi,
                                                   logic [31:0] la, logic [31:0] raw);
        tree_answer_t ans;
        logic [31:0]  n, node, found;
        int           k;
        k         = $signed(raw);
        n         = (leaves_used < LEAVES) ? leaves_used : LEAVES;
        ans.total = 0;
        ans.pos   = 0;
        ans.stat  = ST_OK;
        case (op)
            OP_ADD:
            begin
                if (fi >= 1 && fi <= n)
                begin
                    node = (fi - 1) | LEAVES;
                    node_q[node] = node_q[node] + raw;
                    node = node >> 1;
                    while (node != 0)
                    begin
                        node_q[node] = node_q[2*node] + node_q[2*node+1];
                        node = node >> 1;
                    end
                end
                else
                    ans.stat = ST_BADARG;
            end
            OP_SUM:
            begin
                if (fi >= 1 && fi <= la && la <= n)
                    ans.total = span_total(fi, la);
                else
                    ans.stat = ST_BADARG;
            end
            OP_RIGHT:
            begin
                if (fi >= 1 && fi <= n && k >= 1)
                begin
                    if (short_of(span_total(fi, n), k))
                        ans.stat = ST_NOTFND;
                    else
                    begin
                        found = walk_right(fi, n, k);
                        if (found > n)
                            found = n;
                        ans.pos = IDX_W'(found + 1);
                    end
                end
                else
                    ans.stat = ST_BADARG;
            end
            default:
            begin
                if (la >= 1 && la <= n && k >= 1)
                begin
                    if (short_of(span_total(1, la), k))
                        ans.stat = ST_NOTFND;
                    else
                    begin
                        found = walk_left(la, k);
                        ans.pos = IDX_W'((found > 1) ? found - 1 : 1);
                    end
                end
                else
                    ans.stat = ST_BADARG;
            end
        endcase
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tree_answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 2*LEAVES; i++)
                node_q[i] = 0;
            leaves_used = 1024;
            answer_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
                leaves_used = 32'(cfg_wdata);
            if (in_valid && !in_stall)
                answer_q.push_back(apply_request(opcode, 32'(first_index),
                                                 32'(last_index), operand_value));
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (sum_value !== want.total || position !== want.pos
                        || status !== want.stat)
                        fail_count <= fail_count + 1;
                    if (sum_value !== want.total)
                        $error("sum_value: expected %0d, got %0d",
                               $signed(want.total), sum_value);
                    if (position !== want.pos)
                        $error("position: expected %0d, got %0d", want.pos, position);
                    if (status !== want.stat)
                        $error("status: expected %0d, got %0d", want.stat, status);
                end
            end
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the sum segment tree. Every check lives in the
// checker instance; this module only drives transactions and size writes,
// stalls the result side and decides the outcome.
module tb;
    import sst_pkg::*;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [IDX_W-1:0]          cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [1:0]                opcode = OP_ADD;
    logic [IDX_W-1:0]          first_index = '0;
    logic [IDX_W-1:0]          last_index = '0;
    logic signed [DATA_W-1:0]  operand_value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [DATA_W-1:0]  sum_value;
    logic [IDX_W-1:0]          position;
    logic [1:0]                status;
    int                        fail_count;
    int                        pending;
    logic                      calm = 1'b0;
    int                        stall_left;
    int unsigned               span;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sum_segment_tree dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .first_index(first_index), .last_index(last_index),
        .operand_value(operand_value), .out_valid(out_valid), .out_stall(out_stall),
        .sum_value(sum_value), .position(position), .status(status)
    );

    sum_segment_tree_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .first_index(first_index), .last_index(last_index),
        .operand_value(operand_value), .out_valid(out_valid), .out_stall(out_stall),
        .sum_value(sum_value), .position(position), .status(status),
        .fail_count(fail_count), .pending(pending)
    );

    // The result side stalls in random bursts, with quiet spells
    // in between; once the run enters its calm tail it stops stalling.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (calm)
            out_stall <= 1'b0;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 16);
        end
        else
            out_stall <= 1'b0;
    end

    // Offers one transaction and holds it until it is accepted. Valid is left
    // high afterwards so that back-to-back transactions need no extra edge.
    task automatic offer(logic [1:0] op, logic [IDX_W-1:0] fi, logic [IDX_W-1:0] la,
                         logic [31:0] val);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        first_index   <= fi;
        last_index    <= la;
        operand_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drains the block, then writes the size register once no result is outstanding.
    task automatic resize(logic [IDX_W-1:0] n);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we <= 1'b0;
        span   = (n < LEAVES) ? n : LEAVES;
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        if (span == 0 || $urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, 2047));
        return IDX_W'($urandom_range(1, span));
    endfunction

    function automatic logic [31:0] pick_addend();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, 150) - 50;
    endfunction

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 0;
            default: return $urandom_range(1, 3000);
        endcase
    endfunction

    task automatic random_burst(int count);
        logic [IDX_W-1:0] a, b, t;
        logic [1:0]       op;
        for (int i = 0; i < count; i++)
        begin
            a  = pick_index();
            b  = pick_index();
            op = 2'($urandom_range(0, 3));
            if (op == OP_SUM && a > b && $urandom_range(0, 5) != 0)
            begin
                t = a;
                a = b;
                b = t;
            end
            case (op)
                OP_ADD:  offer(OP_ADD, a, IDX_W'($urandom), pick_addend());
                OP_SUM:  offer(OP_SUM, a, b, $urandom);
                default: offer(op, a, b, pick_threshold());
            endcase
        end
    endtask

    initial
    begin
        span = LEAVES;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at full size: extremes of values and indices, every
        // operation, bad arguments, searches that miss and wrapping sums.
        resize(11'd1024);
        offer(OP_ADD, 11'd1, 11'd0, 32'h7fffffff);
        offer(OP_ADD, 11'd1024, 11'd2047, 32'h80000000);
        offer(OP_ADD, 11'd1, 11'd0, 32'd1);
        offer(OP_SUM, 11'd1, 11'd1024, 32'hffffffff);
        offer(OP_SUM, 11'd1, 11'd1, 32'd0);
        offer(OP_SUM, 11'd5, 11'd4, 32'd0);
        offer(OP_SUM, 11'd0, 11'd4, 32'd0);
        offer(OP_ADD, 11'd0, 11'd0, 32'd3);
        offer(OP_ADD, 11'd1025, 11'd0, 32'd3);
        offer(OP_ADD, 11'd2047, 11'd0, 32'd3);
        offer(OP_ADD, 11'd512, 11'd0, 32'hffffff00);
        offer(OP_ADD, 11'd700, 11'd0, 32'd400);
        offer(OP_RIGHT, 11'd2, 11'd0, 32'd1);
        offer(OP_RIGHT, 11'd2, 11'd0, 32'd0);
        offer(OP_RIGHT, 11'd2, 11'd0, 32'h80000000);
        offer(OP_RIGHT, 11'd513, 11'd0, 32'h7fffffff);
        offer(OP_LEFT, 11'd2047, 11'd1024, 32'd1);
        offer(OP_LEFT, 11'd0, 11'd600, 32'd5);
        offer(OP_LEFT, 11'd0, 11'd0, 32'd5);
        offer(OP_LEFT, 11'd0, 11'd1024, 32'h7fffffff);

        // Size zero turns every request into a bad argument.
        resize(11'd0);
        offer(OP_ADD, 11'd1, 11'd0, 32'd1);
        offer(OP_SUM, 11'd1, 11'd1, 32'd0);
        offer(OP_RIGHT, 11'd1, 11'd1, 32'd1);
        offer(OP_LEFT, 11'd1, 11'd1, 32'd1);

        resize(11'd1);
        random_burst(150);
        resize(11'd7);
        random_burst(300);

        // Let every result come home once before carrying on.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        random_burst(100);

        resize(11'd2047);
        random_burst(250);
        resize(11'd40);
        random_burst(350);
        resize(11'd1000);
        random_burst(250);
        resize(11'd16);
        calm <= 1'b1;
        random_burst(200);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sst_pkg.sv
rtl/sst_node_ram.sv
rtl/sum_segment_tree.sv
dv/sum_segment_tree_checker.sv
dv/tb.sv
